/* src/nbg_pkg.sv */
// ----------------------------------------------------------------------------
// nbg_pkg
// Shared types and constants of the N-body gravity step core: field widths,
// reset values, operation and register codes, sequencer states and the
// request/response bundles of the arithmetic units.
// ----------------------------------------------------------------------------
package nbg_pkg;

	localparam int MAX_BODIES_DEF = 16;

	localparam int WORD_W   = 32;
	localparam int MASS_W   = 20;
	localparam int TS_W     = 16;
	localparam int PHASE_W  = 16;
	localparam int IN_DATA_W  = 216;
	localparam int OUT_DATA_W = 104;

	// divider and square root datapath widths
	localparam int DVD_W  = 68;
	localparam int DVS_W  = 64;
	localparam int RAD_W  = 64;
	localparam int ROOT_W = 32;

	localparam logic [WORD_W-1:0]  GRAV_RST   = 32'd214748;
	localparam logic [TS_W-1:0]    TSTEP_RST  = 16'd655;
	localparam logic [PHASE_W-1:0] SAMPLE_RST = 16'd100;

	// operation codes
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_STEP  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_GRAV   = 2'd0;
	localparam logic [1:0] CFG_TSTEP  = 2'd1;
	localparam logic [1:0] CFG_SAMPLE = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LOAD,
		ST_REP_RD,
		ST_REP_CAP,
		ST_REP_OUT,
		ST_PR_RD,
		ST_PR_CAP,
		ST_DIFF,
		ST_SQ,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_GM,
		ST_FDIV_GO,
		ST_FDIV_WAIT,
		ST_AMUL,
		ST_ADIV_GO,
		ST_ADIV_WAIT,
		ST_VRD,
		ST_VWR,
		ST_PAIR_NEXT,
		ST_MV_RD,
		ST_MV_MUL,
		ST_MV_WR
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic             start;
		logic [RAD_W-1:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} sqrt_rsp_t;

endpackage

/* src/nbg_div.sv */
// ----------------------------------------------------------------------------
// nbg_div
// Restoring radix-2 divider, one quotient bit per cycle. The dividend is
// shifted out of the quotient register as quotient bits shift in.
// ----------------------------------------------------------------------------
module nbg_div (
	input  logic              clk,
	input  logic              arst_n,
	input  nbg_pkg::div_req_t req,
	output nbg_pkg::div_rsp_t rsp
);
	import nbg_pkg::*;

	localparam int CNT_W = $clog2(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	// trial subtract of the next dividend bit
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

/* src/nbg_isqrt.sv */
// ----------------------------------------------------------------------------
// nbg_isqrt
// Integer square root, digit by digit: two radicand bits and one root bit
// per cycle.
// ----------------------------------------------------------------------------
module nbg_isqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  nbg_pkg::sqrt_req_t req,
	output nbg_pkg::sqrt_rsp_t rsp
);
	import nbg_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W);
	localparam int REM_W = ROOT_W + 2;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W+1:0]  trial;
	logic [REM_W+1:0]  cand;
	logic [REM_W+1:0]  diff;
	logic              ge;

	// compare against 4*root+1
	assign trial = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
	assign cand  = {2'b00, root_q, 2'b01};
	assign diff  = trial - cand;
	assign ge    = (trial >= cand);

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

/* src/nbody_gravity_step_core.sv */
// ----------------------------------------------------------------------------
// nbody_gravity_step_core
// Direct N-body gravity stepper in Q16.16 with a semi-implicit Euler position
// update. Body state lives in synchronous memories.
// ----------------------------------------------------------------------------
// Usage: a load transaction appends a body and a clear transaction empties
// the store. A step transaction first streams every body's position when the
// phase counter is zero, then runs all N*(N-1)/2 pairs and moves the bodies.
// Each pair with a nonzero separation takes one square root and eight
// divisions on a single shared radix-2 divider, which sets the step time.
// The input is taken only while the core is idle; the configuration channel
// is always ready. No input is taken while a step is running.
// ----------------------------------------------------------------------------
module nbody_gravity_step_core #(
	parameter int MAX_BODIES = nbg_pkg::MAX_BODIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// load_pos_x, load_pos_y, load_pos_z, load_vel_x, load_vel_y, load_vel_z,
	// load_mass, load_movable, zero fill
	input  logic [nbg_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// operation
	input  logic [1:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// body_index, pos_x, pos_y, pos_z, zero fill
	output logic [nbg_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic                             m_axis_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [1:0]                       cfg_index,
	input  logic [nbg_pkg::WORD_W-1:0]       cfg_data
);
	import nbg_pkg::*;

	localparam int IW     = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
	localparam int CW     = $clog2(MAX_BODIES + 1);
	localparam int CW1    = CW + 1;
	localparam int AW     = IW + 2;
	localparam int PDEPTH = 1 << AW;
	localparam int MM_W   = MASS_W + 1;

	// saturate a 34-bit two's complement value to 32 bits
	function automatic logic [WORD_W-1:0] sat32(input logic [WORD_W+1:0] v);
		logic [WORD_W-1:0] r;
		if (!v[WORD_W+1] && (v[WORD_W:WORD_W-1] != 2'b00))
			r = {1'b0, {(WORD_W-1){1'b1}}};
		else if (v[WORD_W+1] && (v[WORD_W:WORD_W-1] != 2'b11))
			r = {1'b1, {(WORD_W-1){1'b0}}};
		else
			r = v[WORD_W-1:0];
		return r;
	endfunction

	// clamp a quotient to 2^31-1
	function automatic logic [WORD_W-2:0] sat31(input logic [DVD_W-1:0] q);
		logic [WORD_W-2:0] r;
		if (|q[DVD_W-1:WORD_W-1])
			r = '1;
		else
			r = q[WORD_W-2:0];
		return r;
	endfunction

	// control state
	state_t            state_q, state_d;
	logic [1:0]        ax_q, ax_d;
	logic              side_q, side_d;
	logic [CW-1:0]     i_q, i_d;
	logic [CW-1:0]     j_q, j_d;
	logic [CW-1:0]     count_q, count_d;
	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [WORD_W-1:0] grav_q;
	logic [TS_W-1:0]   tstep_q;
	logic [PHASE_W-1:0] sample_q;

	// payload registers
	logic [WORD_W-1:0] ld_pos_q [3];
	logic [WORD_W-1:0] ld_vel_q [3];
	logic [MASS_W-1:0] ld_mass_q;
	logic              ld_mov_q;
	logic [WORD_W-1:0] pw_q [3];
	logic [WORD_W-1:0] pi_q [3];
	logic [WORD_W-1:0] pj_q [3];
	logic [MASS_W-1:0] mi_q, mj_q;
	logic [WORD_W-1:0] e_q [3];
	logic              neg_q [3];
	logic              shr_q;
	logic [RAD_W-1:0]  r2_q;
	logic [ROOT_W-1:0] root_q;
	logic [WORD_W+MASS_W-1:0] gm_q;
	logic [WORD_W-2:0] fi_q, fj_q, ai_q, aj_q;
	logic [2*WORD_W-3:0] prod_q;
	logic signed [47:0] mvp_q;
	logic [WORD_W-1:0] mpos_q;
	logic              mov_q;

	// output register
	logic              o_valid_q;
	logic [3:0]        o_idx_q;
	logic [WORD_W-1:0] o_pos_q [3];
	logic              o_last_q;
	logic              out_load;

	// memories
	logic [WORD_W-1:0] pos_mem [PDEPTH];
	logic [WORD_W-1:0] vel_mem [PDEPTH];
	logic [MM_W-1:0]   mm_mem  [MAX_BODIES];
	logic [WORD_W-1:0] pos_rd, vel_rd;
	logic [MM_W-1:0]   mm_rd;
	logic              pos_we, vel_we, mm_we;
	logic [AW-1:0]     pos_waddr, pos_raddr, vel_waddr, vel_raddr;
	logic [WORD_W-1:0] pos_wdata, vel_wdata;
	logic [IW-1:0]     mm_waddr, mm_raddr;

	// arithmetic units
	div_req_t  div_req;
	div_rsp_t  div_rsp;
	sqrt_req_t sqrt_req;
	sqrt_rsp_t sqrt_rsp;

	// derived values
	logic [IW-1:0]      bi, bj, sel_idx, cnt_idx;
	logic [WORD_W:0]    d_w [3];
	logic [WORD_W:0]    mag_w [3];
	logic               any_w, shr_w, last_w, multi_w;
	logic [WORD_W-2:0]  es_w;
	logic [WORD_W-1:0]  es_full;
	logic [2*WORD_W-3:0] sq_w;
	logic [WORD_W-2:0]  a_sel;
	logic [WORD_W+1:0]  vext, aext, vsum;
	logic [47:0]        mmag;
	logic [WORD_W+1:0]  pext, dext, msum;
	logic [PHASE_W:0]   phase_inc;
	logic [PHASE_W-1:0] phase_wrap;
	logic [CW+3:0]      idx_ext;

	assign bi      = i_q[IW-1:0];
	assign bj      = j_q[IW-1:0];
	assign sel_idx = side_q ? bj : bi;
	assign cnt_idx = count_q[IW-1:0];
	assign last_w  = (CW1'(i_q) + CW1'(1)) == CW1'(count_q);
	assign multi_w = (count_q > CW'(1));
	assign idx_ext = {4'b0000, i_q};

	// pair separation per axis
	always_comb begin
		any_w = 1'b0;
		shr_w = 1'b0;
		for (int k = 0; k < 3; k++) begin
			d_w[k]   = {pj_q[k][WORD_W-1], pj_q[k]} - {pi_q[k][WORD_W-1], pi_q[k]};
			mag_w[k] = d_w[k][WORD_W] ? (~d_w[k] + (WORD_W+1)'(1)) : d_w[k];
			any_w    = any_w | (|mag_w[k][WORD_W-1:0]);
			shr_w    = shr_w | mag_w[k][WORD_W-1];
		end
	end

	assign es_full = shr_q ? (e_q[ax_q] >> 1) : e_q[ax_q];
	assign es_w    = es_full[WORD_W-2:0];
	assign sq_w    = es_w * es_w;

	// velocity update: body i gains the pull toward j, body j the opposite
	assign a_sel = side_q ? aj_q : ai_q;
	assign vext  = {{2{vel_rd[WORD_W-1]}}, vel_rd};
	assign aext  = {3'b000, a_sel};
	assign vsum  = (neg_q[ax_q] ^ side_q) ? (vext - aext) : (vext + aext);

	// position update, truncated toward zero
	assign mmag = mvp_q[47] ? 48'(-mvp_q) : 48'(mvp_q);
	assign pext = {{2{mpos_q[WORD_W-1]}}, mpos_q};
	assign dext = {2'b00, mmag[47:16]};
	assign msum = mvp_q[47] ? (pext - dext) : (pext + dext);

	assign phase_inc  = {1'b0, phase_q} + (PHASE_W+1)'(1);
	assign phase_wrap = (phase_inc >= {1'b0, sample_q}) ? '0 : phase_inc[PHASE_W-1:0];

	// sequencer: next state and strobes
	always_comb begin
		state_d   = state_q;
		ax_d      = ax_q;
		side_d    = side_q;
		i_d       = i_q;
		j_d       = j_q;
		count_d   = count_q;
		phase_d   = phase_q;
		s_axis_tready = 1'b0;
		out_load  = 1'b0;
		pos_we    = 1'b0;
		vel_we    = 1'b0;
		mm_we     = 1'b0;
		pos_waddr = {bi, ax_q};
		pos_raddr = {bi, ax_q};
		vel_waddr = {sel_idx, ax_q};
		vel_raddr = {sel_idx, ax_q};
		pos_wdata = sat32(msum);
		vel_wdata = sat32(vsum);
		mm_waddr  = cnt_idx;
		mm_raddr  = bi;
		div_req.start    = 1'b0;
		div_req.dividend = shr_q ? {2'b00, gm_q, 14'd0} : {gm_q, 16'd0};
		div_req.divisor  = r2_q;
		sqrt_req.start    = 1'b0;
		sqrt_req.radicand = r2_q;

		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					unique case (s_axis_tuser)
						OP_LOAD: begin
							if (count_q < CW'(MAX_BODIES)) begin
								ax_d    = 2'd0;
								state_d = ST_LOAD;
							end
						end
						OP_CLEAR: begin
							count_d = '0;
							phase_d = '0;
						end
						OP_STEP: begin
							phase_d = phase_wrap;
							if (count_q != '0) begin
								i_d    = '0;
								ax_d   = 2'd0;
								side_d = 1'b0;
								if (phase_q == '0) begin
									state_d = ST_REP_RD;
								end else if (multi_w) begin
									j_d     = CW'(1);
									state_d = ST_PR_RD;
								end else begin
									state_d = ST_MV_RD;
								end
							end
						end
						default: ;
					endcase
				end
			end
			ST_LOAD: begin
				pos_we    = 1'b1;
				vel_we    = 1'b1;
				mm_we     = 1'b1;
				pos_waddr = {cnt_idx, ax_q};
				vel_waddr = {cnt_idx, ax_q};
				pos_wdata = ld_pos_q[ax_q];
				vel_wdata = ld_vel_q[ax_q];
				if (ax_q == 2'd2) begin
					count_d = count_q + CW'(1);
					state_d = ST_IDLE;
				end else begin
					ax_d = ax_q + 2'd1;
				end
			end
			ST_REP_RD: begin
				state_d = ST_REP_CAP;
			end
			ST_REP_CAP: begin
				if (ax_q == 2'd2) begin
					state_d = ST_REP_OUT;
				end else begin
					ax_d    = ax_q + 2'd1;
					state_d = ST_REP_RD;
				end
			end
			ST_REP_OUT: begin
				if (!o_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					ax_d     = 2'd0;
					side_d   = 1'b0;
					if (last_w) begin
						i_d = '0;
						if (multi_w) begin
							j_d     = CW'(1);
							state_d = ST_PR_RD;
						end else begin
							state_d = ST_MV_RD;
						end
					end else begin
						i_d     = i_q + CW'(1);
						state_d = ST_REP_RD;
					end
				end
			end
			ST_PR_RD: begin
				pos_raddr = {sel_idx, ax_q};
				mm_raddr  = sel_idx;
				state_d   = ST_PR_CAP;
			end
			ST_PR_CAP: begin
				side_d  = !side_q;
				state_d = ST_PR_RD;
				if (side_q) begin
					if (ax_q == 2'd2) begin
						ax_d    = 2'd0;
						state_d = ST_DIFF;
					end else begin
						ax_d = ax_q + 2'd1;
					end
				end
			end
			ST_DIFF: begin
				ax_d    = 2'd0;
				state_d = any_w ? ST_SQ : ST_PAIR_NEXT;
			end
			ST_SQ: begin
				if (ax_q == 2'd2) begin
					ax_d    = 2'd0;
					state_d = ST_SQRT_GO;
				end else begin
					ax_d = ax_q + 2'd1;
				end
			end
			ST_SQRT_GO: begin
				sqrt_req.start = 1'b1;
				state_d        = ST_SQRT_WAIT;
			end
			ST_SQRT_WAIT: begin
				if (sqrt_rsp.done) begin
					side_d  = 1'b0;
					state_d = ST_GM;
				end
			end
			ST_GM: begin
				state_d = ST_FDIV_GO;
			end
			ST_FDIV_GO: begin
				div_req.start = 1'b1;
				state_d       = ST_FDIV_WAIT;
			end
			ST_FDIV_WAIT: begin
				if (div_rsp.done) begin
					if (!side_q) begin
						side_d  = 1'b1;
						state_d = ST_GM;
					end else begin
						side_d  = 1'b0;
						ax_d    = 2'd0;
						state_d = ST_AMUL;
					end
				end
			end
			ST_AMUL: begin
				state_d = ST_ADIV_GO;
			end
			ST_ADIV_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = {6'd0, prod_q};
				div_req.divisor  = {32'd0, root_q};
				state_d          = ST_ADIV_WAIT;
			end
			ST_ADIV_WAIT: begin
				if (div_rsp.done) begin
					if (!side_q) begin
						side_d  = 1'b1;
						state_d = ST_AMUL;
					end else begin
						side_d  = 1'b0;
						state_d = ST_VRD;
					end
				end
			end
			ST_VRD: begin
				state_d = ST_VWR;
			end
			ST_VWR: begin
				vel_we = 1'b1;
				if (!side_q) begin
					side_d  = 1'b1;
					state_d = ST_VRD;
				end else begin
					side_d = 1'b0;
					if (ax_q == 2'd2) begin
						ax_d    = 2'd0;
						state_d = ST_PAIR_NEXT;
					end else begin
						ax_d    = ax_q + 2'd1;
						state_d = ST_AMUL;
					end
				end
			end
			ST_PAIR_NEXT: begin
				ax_d   = 2'd0;
				side_d = 1'b0;
				if ((CW1'(j_q) + CW1'(1)) < CW1'(count_q)) begin
					j_d     = j_q + CW'(1);
					state_d = ST_PR_RD;
				end else if ((CW1'(i_q) + CW1'(2)) < CW1'(count_q)) begin
					i_d     = i_q + CW'(1);
					j_d     = i_q + CW'(2);
					state_d = ST_PR_RD;
				end else begin
					i_d     = '0;
					state_d = ST_MV_RD;
				end
			end
			ST_MV_RD: begin
				vel_raddr = {bi, ax_q};
				state_d   = ST_MV_MUL;
			end
			ST_MV_MUL: begin
				state_d = ST_MV_WR;
			end
			ST_MV_WR: begin
				pos_we  = mov_q;
				state_d = ST_MV_RD;
				if (ax_q == 2'd2) begin
					ax_d = 2'd0;
					if (last_w) begin
						state_d = ST_IDLE;
					end else begin
						i_d = i_q + CW'(1);
					end
				end else begin
					ax_d = ax_q + 2'd1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ax_q     <= 2'd0;
			side_q   <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			count_q  <= '0;
			phase_q  <= '0;
			grav_q   <= GRAV_RST;
			tstep_q  <= TSTEP_RST;
			sample_q <= SAMPLE_RST;
		end else begin
			state_q <= state_d;
			ax_q    <= ax_d;
			side_q  <= side_d;
			i_q     <= i_d;
			j_q     <= j_d;
			count_q <= count_d;
			phase_q <= phase_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_GRAV:   grav_q   <= cfg_data;
					CFG_TSTEP:  tstep_q  <= cfg_data[TS_W-1:0];
					CFG_SAMPLE: sample_q <= cfg_data[PHASE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	assign cfg_ready = 1'b1;

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			for (int k = 0; k < 3; k++) begin
				ld_pos_q[k] <= s_axis_tdata[k*WORD_W +: WORD_W];
				ld_vel_q[k] <= s_axis_tdata[(k+3)*WORD_W +: WORD_W];
			end
			ld_mass_q <= s_axis_tdata[6*WORD_W +: MASS_W];
			ld_mov_q  <= s_axis_tdata[6*WORD_W + MASS_W];
		end
		unique case (state_q)
			ST_REP_CAP: pw_q[ax_q] <= pos_rd;
			ST_PR_CAP: begin
				if (side_q) begin
					pj_q[ax_q] <= pos_rd;
					mj_q       <= mm_rd[MASS_W-1:0];
				end else begin
					pi_q[ax_q] <= pos_rd;
					mi_q       <= mm_rd[MASS_W-1:0];
				end
			end
			ST_DIFF: begin
				for (int k = 0; k < 3; k++) begin
					e_q[k]   <= mag_w[k][WORD_W-1:0];
					neg_q[k] <= d_w[k][WORD_W];
				end
				shr_q <= shr_w;
				r2_q  <= '0;
			end
			ST_SQ: r2_q <= r2_q + RAD_W'(sq_w);
			ST_SQRT_WAIT: begin
				if (sqrt_rsp.done)
					root_q <= sqrt_rsp.root;
			end
			ST_GM: gm_q <= grav_q * (side_q ? mi_q : mj_q);
			ST_FDIV_WAIT: begin
				if (div_rsp.done) begin
					if (side_q)
						fj_q <= sat31(div_rsp.quot);
					else
						fi_q <= sat31(div_rsp.quot);
				end
			end
			ST_AMUL: prod_q <= (side_q ? fj_q : fi_q) * es_w;
			ST_ADIV_WAIT: begin
				if (div_rsp.done) begin
					if (side_q)
						aj_q <= sat31(div_rsp.quot);
					else
						ai_q <= sat31(div_rsp.quot);
				end
			end
			ST_MV_MUL: begin
				mvp_q  <= $signed(vel_rd) * $signed({1'b0, tstep_q});
				mpos_q <= pos_rd;
				mov_q  <= mm_rd[MASS_W];
			end
			default: ;
		endcase
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (out_load) begin
			o_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_idx_q  <= idx_ext[3:0];
			o_pos_q  <= pw_q;
			o_last_q <= last_w;
		end
	end

	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = {4'b0000, o_pos_q[2], o_pos_q[1], o_pos_q[0], o_idx_q};

	// body memories with registered read
	always_ff @(posedge clk) begin
		if (pos_we)
			pos_mem[pos_waddr] <= pos_wdata;
		pos_rd <= pos_mem[pos_raddr];
	end

	always_ff @(posedge clk) begin
		if (vel_we)
			vel_mem[vel_waddr] <= vel_wdata;
		vel_rd <= vel_mem[vel_raddr];
	end

	always_ff @(posedge clk) begin
		if (mm_we)
			mm_mem[mm_waddr] <= {ld_mov_q, ld_mass_q};
		mm_rd <= mm_mem[mm_raddr];
	end

	nbg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	nbg_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sqrt_req),
		.rsp    (sqrt_rsp)
	);

endmodule
